@@ hw/rtl/sorted_value_table_assert.svh @@
`ifndef SORTED_VALUE_TABLE_ASSERT_SVH
`define SORTED_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define SVT_ASSERT_IMPL(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define SVT_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ hw/rtl/svt_pkg.sv @@
package svt_pkg;

    localparam int CAPACITY    = 16;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int MATCH_W     = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int IN_PAD_W    = 5;
    localparam int OUT_PAD_W   = 5;
    localparam int IN_TDATA_W  = IN_PAD_W + DATA_W + OP_W;
    localparam int OUT_TDATA_W = OUT_PAD_W + 2 * DATA_W + COUNT_OUT_W + MATCH_W + STATUS_W;
    localparam int PADDR_W     = 3;

    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_ALL   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // register index of the sort rule
    localparam logic REG_SORT_DESC = 1'b0;

    typedef logic signed [DATA_W-1:0] entry_t;

    typedef struct packed {
        logic   ins_en;
        logic   del_en;
        logic   desc;
        entry_t value;
    } cell_cmd_t;

    typedef struct packed {
        logic             any_match;
        logic [IDX_W-1:0] match_idx;
    } chain_status_t;

    typedef struct packed {
        logic [IN_PAD_W-1:0] pad;
        entry_t              value;
        logic [OP_W-1:0]     operation;
    } in_item_t;

    typedef struct packed {
        logic [OUT_PAD_W-1:0]   pad;
        entry_t                 tail_value;
        entry_t                 head_value;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic [MATCH_W-1:0]     match_position;
        logic [STATUS_W-1:0]    status;
    } result_t;

endpackage

@@ hw/rtl/svt_cell.sv @@
module svt_cell import svt_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      occupied,
    input  entry_t    entry_prev,
    input  entry_t    entry_nxt,
    input  logic      ins_after_in,
    input  logic      del_seen_in,
    output logic      ins_after_out,
    output logic      del_seen_out,
    output entry_t    entry_o
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   brk;
    logic   hit;

    // insertion point is the first held entry that must follow the new value
    assign brk = cmd.desc ? ($signed(entry_reg) < $signed(cmd.value))
                          : ($signed(entry_reg) > $signed(cmd.value));
    assign hit = occupied && (entry_reg == cmd.value);

    assign ins_after_out = ins_after_in || !occupied || brk;
    assign del_seen_out  = del_seen_in || hit;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins_en) begin
            if (ins_after_in) begin
                entry_next = entry_prev;
            end else if (ins_after_out) begin
                entry_next = cmd.value;
            end
        end else if (cmd.del_en && del_seen_out) begin
            entry_next = entry_nxt;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_o = entry_reg;

endmodule

@@ hw/rtl/svt_chain.sv @@
module svt_chain import svt_pkg::*; (
    input  logic                           aclk,
    input  cell_cmd_t                      cmd,
    input  logic [CNT_W-1:0]               count,
    output chain_status_t                  status,
    output logic [CAPACITY-1:0][DATA_W-1:0] entries
);

    logic [CAPACITY:0]   ins_after;
    logic [CAPACITY:0]   del_seen;
    logic [CAPACITY-1:0] first_hit;
    logic [IDX_W-1:0]    idx;

    assign ins_after[0] = 1'b0;
    assign del_seen[0]  = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t prev_q;
        entry_t next_q;
        entry_t ent_q;

        if (i == 0) begin : g_first
            assign prev_q = cmd.value;
        end else begin : g_mid
            assign prev_q = entries[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign next_q = ent_q;
        end else begin : g_body
            assign next_q = entries[i+1];
        end

        svt_cell u_cell (
            .aclk          (aclk),
            .cmd           (cmd),
            .occupied      (count > CNT_W'(i)),
            .entry_prev    (prev_q),
            .entry_nxt     (next_q),
            .ins_after_in  (ins_after[i]),
            .del_seen_in   (del_seen[i]),
            .ins_after_out (ins_after[i+1]),
            .del_seen_out  (del_seen[i+1]),
            .entry_o       (ent_q)
        );

        assign entries[i]   = ent_q;
        assign first_hit[i] = del_seen[i+1] && !del_seen[i];
    end

    // first_hit is one-hot or empty, so an or of the indices encodes it
    always_comb begin
        idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first_hit[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
    end

    assign status.any_match = del_seen[CAPACITY];
    assign status.match_idx = idx;

endmodule

@@ hw/rtl/sorted_value_table.sv @@
// sorted value table: a row of cells holds up to CAPACITY signed 32-bit
// entries in ascending or descending order (sort_descending register).
// input stream s_*: one transaction carries an operation and a value.
// result stream m_*: one transaction per input with status, match position,
// entry count and the head and tail entries after the operation.
// apb port: register sort_descending at byte address 0, written with the
// apb write handshake; the table is not re-sorted when the rule changes.
// timing: a new item is accepted only once the result of the last one has
// loaded. insert, delete-first, lookup, clear: every cell compares and
// shifts in the acceptance cycle, the result register loads in S_RESP
// once the output register is free. delete-all removes one match per cycle
// through the cell row in S_PURGE, then its result register loads likewise.
// reset empties the table, selects ascending order and drops any result.
// a stalled result is held in the output register; the next item is
// accepted meanwhile and its result waits until the register frees.
module sorted_value_table import svt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // operation[2:0], value[34:3], zero pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // status, match_position, entry_count,
                                             // head_value, tail_value, zero pad
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PURGE = 2'd1;
    localparam logic [1:0] S_RESP  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                desc_reg;
    logic                found_reg, found_next;
    entry_t              value_reg, value_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [MATCH_W-1:0]  match_reg, match_next;
    logic                m_valid_reg;
    result_t             result_reg;

    in_item_t                        in_item;
    cell_cmd_t                       cmd;
    chain_status_t                   chain_st;
    logic [CAPACITY-1:0][DATA_W-1:0] entries;
    logic                            in_acc;
    logic                            is_empty;
    logic                            is_full;
    logic                            load_out;
    logic [IDX_W-1:0]                tail_idx;
    result_t                         result_d;
    logic                            cfg_wr;

    assign in_item  = in_item_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(CAPACITY));

    assign cmd.value  = (state_reg == S_IDLE) ? in_item.value : value_reg;
    assign cmd.desc   = desc_reg;
    assign cmd.ins_en = in_acc && (in_item.operation == OP_INSERT) && !is_full;
    assign cmd.del_en = (in_acc && (in_item.operation == OP_DEL_FIRST) && chain_st.any_match)
                     || ((state_reg == S_PURGE) && chain_st.any_match);

    svt_chain u_chain (
        .aclk    (aclk),
        .cmd     (cmd),
        .count   (count_reg),
        .status  (chain_st),
        .entries (entries)
    );

    assign load_out = (state_reg == S_RESP) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        found_next  = found_reg;
        value_next  = value_reg;
        status_next = status_reg;
        match_next  = match_reg;
        if (cmd.ins_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.del_en) begin
            count_next = count_reg - CNT_W'(1);
        end
        unique case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    value_next  = in_item.value;
                    found_next  = 1'b0;
                    match_next  = '0;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    unique case (in_item.operation)
                        OP_INSERT: begin
                            if (is_full) status_next = ST_FULL;
                        end
                        OP_DEL_FIRST: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else if (!chain_st.any_match) begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_DEL_ALL: begin
                            state_next = S_PURGE;
                        end
                        OP_LOOKUP: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else if (!chain_st.any_match) begin
                                status_next = ST_NOT_FOUND;
                            end else begin
                                match_next = MATCH_W'(chain_st.match_idx);
                            end
                        end
                        OP_CLEAR: begin
                            if (is_empty) status_next = ST_EMPTY;
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PURGE: begin
                // one match leaves the row per cycle until none is left
                if (chain_st.any_match) begin
                    found_next = 1'b1;
                end else begin
                    priority if (found_reg) begin
                        status_next = ST_OK;
                    end else if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (load_out) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        result_d                = '0;
        result_d.status         = status_reg;
        result_d.match_position = match_reg;
        result_d.entry_count    = COUNT_OUT_W'(count_reg);
        if (!is_empty) begin
            result_d.head_value = entries[0];
            result_d.tail_value = entries[tail_idx];
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            desc_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            if (cfg_wr && (paddr[PADDR_W-1] == REG_SORT_DESC)) begin
                desc_reg <= pwdata[0];
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        status_reg <= status_next;
        match_reg  <= match_next;
        if (load_out) begin
            result_reg <= result_d;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = result_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[PADDR_W-1] == REG_SORT_DESC) ? DATA_W'(desc_reg) : '0;

endmodule

@@ hw/rtl/svt_checker.sv @@
`include "sorted_value_table_assert.svh"

module svt_checker import svt_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    result_t res;

    assign res = result_t'(m_tdata);

    // a stalled result transaction holds its payload
    `SVT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one item in flight: acceptance is followed by a busy cycle
    `SVT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input accepted on consecutive cycles")

    // a full report always comes with a full table
    `SVT_ASSERT_IMPL(a_full_count, m_tvalid && (res.status == ST_FULL), res.entry_count == COUNT_OUT_W'(CAPACITY), "full status with wrong count")

    // an empty report leaves the table empty with zero head and tail
    `SVT_ASSERT_IMPL(a_empty_zero, m_tvalid && (res.status == ST_EMPTY), (res.entry_count == '0) && (res.head_value == '0) && (res.tail_value == '0), "empty status with entries")

endmodule

bind sorted_value_table svt_checker u_svt_checker (.*);
